>>> rtl/jsv_pkg.sv
// shared types, codes and character helpers for the json syntax validator
`default_nettype none

package jsv_pkg;

  // default nesting limit, the top-level bracket counts as one level
  localparam int unsigned MAX_NEST_DEPTH = 32;

  // parser state codes
  localparam logic [3:0] ST_START     = 4'd0;
  localparam logic [3:0] ST_ARR_FIRST = 4'd1;
  localparam logic [3:0] ST_OBJ_FIRST = 4'd2;
  localparam logic [3:0] ST_VALUE     = 4'd3;
  localparam logic [3:0] ST_KEY       = 4'd4;
  localparam logic [3:0] ST_KEY_STR   = 4'd5;
  localparam logic [3:0] ST_KEY_ESC   = 4'd6;
  localparam logic [3:0] ST_COLON     = 4'd7;
  localparam logic [3:0] ST_STR       = 4'd8;
  localparam logic [3:0] ST_STR_ESC   = 4'd9;
  localparam logic [3:0] ST_LIT       = 4'd10;
  localparam logic [3:0] ST_NUM_INT   = 4'd11;
  localparam logic [3:0] ST_NUM_FRAC  = 4'd12;
  localparam logic [3:0] ST_NUM_ESIGN = 4'd13;
  localparam logic [3:0] ST_NUM_EDIG  = 4'd14;
  localparam logic [3:0] ST_AFTER     = 4'd15;

  // verdict codes
  localparam logic [1:0] VERDICT_OK        = 2'd0;
  localparam logic [1:0] VERDICT_BAD_START = 2'd1;
  localparam logic [1:0] VERDICT_MALFORMED = 2'd2;
  localparam logic [1:0] VERDICT_TOO_DEEP  = 2'd3;

  // nesting kinds
  localparam logic KIND_ARRAY  = 1'b0;
  localparam logic KIND_OBJECT = 1'b1;

  // literal kinds
  localparam logic [1:0] LIT_TRUE  = 2'd0;
  localparam logic [1:0] LIT_FALSE = 2'd1;
  localparam logic [1:0] LIT_NULL  = 2'd2;

  // characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_UPPER_E = 8'h45;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LOWER_E = 8'h65;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [7:0] CH_LOWER_N = 8'h6E;
  localparam logic [7:0] CH_LOWER_T = 8'h74;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // command from the parser to the kind stack
  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
    logic kind;
  } stk_cmd_t;

  function automatic logic is_ws(input logic [7:0] c);
    return c inside {CH_SPACE, CH_TAB, CH_LF, CH_CR};
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[CH_ZERO:CH_NINE]};
  endfunction

  // length of a literal, unknown kinds fall back to true
  function automatic logic [2:0] lit_len(input logic [1:0] kind);
    return (kind == LIT_FALSE) ? 3'd5 : 3'd4;
  endfunction

  // character at a position of a literal
  function automatic logic [7:0] lit_char(input logic [1:0] kind, input logic [2:0] idx);
    logic [7:0] ch;
    ch = CH_NUL;
    case (kind)
      LIT_FALSE: begin
        case (idx)
          3'd0:    ch = 8'h66;
          3'd1:    ch = 8'h61;
          3'd2:    ch = 8'h6C;
          3'd3:    ch = 8'h73;
          3'd4:    ch = 8'h65;
          default: ch = CH_NUL;
        endcase
      end
      LIT_NULL: begin
        case (idx)
          3'd0:    ch = 8'h6E;
          3'd1:    ch = 8'h75;
          3'd2:    ch = 8'h6C;
          3'd3:    ch = 8'h6C;
          default: ch = CH_NUL;
        endcase
      end
      default: begin
        case (idx)
          3'd0:    ch = 8'h74;
          3'd1:    ch = 8'h72;
          3'd2:    ch = 8'h75;
          3'd3:    ch = 8'h65;
          default: ch = CH_NUL;
        endcase
      end
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

>>> rtl/jsv_kind_stack.sv
// nesting kind stack with registered top, next-below and depth
`default_nettype none

module jsv_kind_stack #(
  parameter int unsigned MaxDepth = jsv_pkg::MAX_NEST_DEPTH,
  localparam int unsigned DepthW  = $clog2(MaxDepth + 1),
  localparam int unsigned AddrW   = (MaxDepth > 1) ? $clog2(MaxDepth) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire jsv_pkg::stk_cmd_t cmd_i,
  output logic [DepthW-1:0]      depth_o,
  output logic                   top_kind_o
);

  logic              mem_q [MaxDepth];
  logic [DepthW-1:0] depth_q, depth_d;
  logic              top_q, top_d;
  logic              below_q;
  logic [AddrW-1:0]  wr_addr;
  logic [AddrW-1:0]  rd_addr;
  logic [DepthW-1:0] rd_depth;

  // push writes at the current depth, pop fetches the entry just below the new top
  assign wr_addr  = depth_q[AddrW-1:0];
  assign rd_depth = depth_q - DepthW'(3);
  assign rd_addr  = rd_depth[AddrW-1:0];

  // depth and top kind
  always_comb begin
    depth_d = depth_q;
    top_d   = top_q;
    if (cmd_i.clear) begin
      depth_d = '0;
      top_d   = jsv_pkg::KIND_ARRAY;
    end else if (cmd_i.push) begin
      depth_d = depth_q + DepthW'(1);
      top_d   = cmd_i.kind;
    end else if (cmd_i.pop) begin
      depth_d = depth_q - DepthW'(1);
      top_d   = below_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
      top_q   <= jsv_pkg::KIND_ARRAY;
    end else begin
      depth_q <= depth_d;
      top_q   <= top_d;
    end
  end

  // stack memory, one write port and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.push && !cmd_i.clear) begin
      mem_q[wr_addr] <= cmd_i.kind;
      below_q        <= top_q;
    end else if (cmd_i.pop && !cmd_i.clear) begin
      below_q        <= mem_q[rd_addr];
    end
  end

  assign depth_o    = depth_q;
  assign top_kind_o = top_q;

endmodule

`default_nettype wire

>>> rtl/jsv_parser.sv
// per-byte grammar state machine, literal matcher, position counter and verdict
`default_nettype none

module jsv_parser #(
  parameter int unsigned MaxDepth = jsv_pkg::MAX_NEST_DEPTH,
  localparam int unsigned DepthW  = $clog2(MaxDepth + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire logic [7:0]        text_byte_i,
  input  wire logic              is_last_i,
  input  wire logic [DepthW-1:0] depth_i,
  input  wire logic              top_kind_i,
  output jsv_pkg::stk_cmd_t      stk_cmd_o,
  output logic                   res_valid_o,
  output logic [1:0]             res_verdict_o,
  output logic [15:0]            res_pos_o
);

  logic [3:0]  st_q, st_d;
  logic [1:0]  lit_kind_q, lit_kind_d;
  logic [2:0]  lit_idx_q, lit_idx_d;
  logic [2:0]  lit_idx_inc;
  logic        given_q;
  logic [15:0] pos_q;

  logic        ws, dig, is_e;
  logic        hit;
  logic [1:0]  hit_code;
  logic        vstart, after_mode;
  logic        do_open, open_kind, do_close;
  logic        push_c, pop_c;
  logic [7:0]  c;

  assign c           = text_byte_i;
  assign ws          = jsv_pkg::is_ws(c);
  assign dig         = jsv_pkg::is_digit(c);
  assign is_e        = (c == jsv_pkg::CH_LOWER_E) || (c == jsv_pkg::CH_UPPER_E);
  assign lit_idx_inc = lit_idx_q + 3'd1;

  // next state for one byte
  always_comb begin
    st_d       = st_q;
    lit_kind_d = lit_kind_q;
    lit_idx_d  = lit_idx_q;
    hit        = 1'b0;
    hit_code   = jsv_pkg::VERDICT_MALFORMED;
    vstart     = 1'b0;
    after_mode = 1'b0;
    do_open    = 1'b0;
    open_kind  = jsv_pkg::KIND_ARRAY;
    do_close   = 1'b0;
    push_c     = 1'b0;
    pop_c      = 1'b0;

    case (st_q)
      jsv_pkg::ST_START: begin
        if (ws) begin
        end else if (c == jsv_pkg::CH_LBRACE) begin
          do_open   = 1'b1;
          open_kind = jsv_pkg::KIND_OBJECT;
        end else if (c == jsv_pkg::CH_LBRACK) begin
          do_open   = 1'b1;
        end else begin
          hit      = 1'b1;
          hit_code = jsv_pkg::VERDICT_BAD_START;
        end
      end
      jsv_pkg::ST_ARR_FIRST: begin
        if (ws) begin
        end else if (c == jsv_pkg::CH_RBRACK) begin
          do_close = 1'b1;
        end else begin
          vstart = 1'b1;
        end
      end
      jsv_pkg::ST_OBJ_FIRST: begin
        if (ws) begin
        end else if (c == jsv_pkg::CH_RBRACE) begin
          do_close = 1'b1;
        end else if (c == jsv_pkg::CH_QUOTE) begin
          st_d = jsv_pkg::ST_KEY_STR;
        end else begin
          hit = 1'b1;
        end
      end
      jsv_pkg::ST_VALUE: begin
        if (!ws) begin
          vstart = 1'b1;
        end
      end
      jsv_pkg::ST_KEY: begin
        if (ws) begin
        end else if (c == jsv_pkg::CH_QUOTE) begin
          st_d = jsv_pkg::ST_KEY_STR;
        end else begin
          hit = 1'b1;
        end
      end
      jsv_pkg::ST_KEY_STR, jsv_pkg::ST_STR: begin
        if (c == jsv_pkg::CH_NUL) begin
          hit = 1'b1;
        end else if (c == jsv_pkg::CH_BSLASH) begin
          st_d = (st_q == jsv_pkg::ST_KEY_STR) ? jsv_pkg::ST_KEY_ESC : jsv_pkg::ST_STR_ESC;
        end else if (c == jsv_pkg::CH_QUOTE) begin
          st_d = (st_q == jsv_pkg::ST_KEY_STR) ? jsv_pkg::ST_COLON : jsv_pkg::ST_AFTER;
        end
      end
      jsv_pkg::ST_KEY_ESC: begin
        if (c == jsv_pkg::CH_NUL) begin
          hit = 1'b1;
        end else begin
          st_d = jsv_pkg::ST_KEY_STR;
        end
      end
      jsv_pkg::ST_STR_ESC: begin
        if (c == jsv_pkg::CH_NUL) begin
          hit = 1'b1;
        end else begin
          st_d = jsv_pkg::ST_STR;
        end
      end
      jsv_pkg::ST_COLON: begin
        if (ws) begin
        end else if (c == jsv_pkg::CH_COLON) begin
          st_d = jsv_pkg::ST_VALUE;
        end else begin
          hit = 1'b1;
        end
      end
      jsv_pkg::ST_LIT: begin
        if ((lit_idx_q >= jsv_pkg::lit_len(lit_kind_q)) ||
            (c != jsv_pkg::lit_char(lit_kind_q, lit_idx_q))) begin
          hit = 1'b1;
        end else begin
          lit_idx_d = lit_idx_inc;
          if (lit_idx_inc >= jsv_pkg::lit_len(lit_kind_q)) begin
            st_d = jsv_pkg::ST_AFTER;
          end
        end
      end
      jsv_pkg::ST_NUM_INT: begin
        if (dig) begin
        end else if (c == jsv_pkg::CH_DOT) begin
          st_d = jsv_pkg::ST_NUM_FRAC;
        end else if (is_e) begin
          st_d = jsv_pkg::ST_NUM_ESIGN;
        end else begin
          after_mode = 1'b1;
        end
      end
      jsv_pkg::ST_NUM_FRAC: begin
        if (dig) begin
        end else if (is_e) begin
          st_d = jsv_pkg::ST_NUM_ESIGN;
        end else begin
          after_mode = 1'b1;
        end
      end
      jsv_pkg::ST_NUM_ESIGN: begin
        if (dig || (c == jsv_pkg::CH_PLUS) || (c == jsv_pkg::CH_MINUS)) begin
          st_d = jsv_pkg::ST_NUM_EDIG;
        end else begin
          after_mode = 1'b1;
        end
      end
      jsv_pkg::ST_NUM_EDIG: begin
        if (!dig) begin
          after_mode = 1'b1;
        end
      end
      jsv_pkg::ST_AFTER: begin
        after_mode = 1'b1;
      end
      default: begin
        hit = 1'b1;
      end
    endcase

    // start of a value
    if (vstart) begin
      if (c == jsv_pkg::CH_QUOTE) begin
        st_d = jsv_pkg::ST_STR;
      end else if (c == jsv_pkg::CH_LBRACE) begin
        do_open   = 1'b1;
        open_kind = jsv_pkg::KIND_OBJECT;
      end else if (c == jsv_pkg::CH_LBRACK) begin
        do_open   = 1'b1;
      end else if (c == jsv_pkg::CH_LOWER_T) begin
        lit_kind_d = jsv_pkg::LIT_TRUE;
        lit_idx_d  = 3'd1;
        st_d       = jsv_pkg::ST_LIT;
      end else if (c == jsv_pkg::CH_LOWER_F) begin
        lit_kind_d = jsv_pkg::LIT_FALSE;
        lit_idx_d  = 3'd1;
        st_d       = jsv_pkg::ST_LIT;
      end else if (c == jsv_pkg::CH_LOWER_N) begin
        lit_kind_d = jsv_pkg::LIT_NULL;
        lit_idx_d  = 3'd1;
        st_d       = jsv_pkg::ST_LIT;
      end else if (dig || (c == jsv_pkg::CH_MINUS)) begin
        st_d = jsv_pkg::ST_NUM_INT;
      end else begin
        hit = 1'b1;
      end
    end

    // after a value, also reached when a number ends on this byte
    if (after_mode) begin
      st_d = jsv_pkg::ST_AFTER;
      if (ws) begin
      end else if (c == jsv_pkg::CH_COMMA) begin
        st_d = (top_kind_i == jsv_pkg::KIND_OBJECT) ? jsv_pkg::ST_KEY : jsv_pkg::ST_VALUE;
      end else if ((c == jsv_pkg::CH_RBRACK) && (top_kind_i == jsv_pkg::KIND_ARRAY)) begin
        do_close = 1'b1;
      end else if ((c == jsv_pkg::CH_RBRACE) && (top_kind_i == jsv_pkg::KIND_OBJECT)) begin
        do_close = 1'b1;
      end else begin
        hit = 1'b1;
      end
    end

    // open a level
    if (do_open) begin
      if (depth_i >= DepthW'(MaxDepth)) begin
        hit      = 1'b1;
        hit_code = jsv_pkg::VERDICT_TOO_DEEP;
      end else begin
        push_c = 1'b1;
        st_d   = (open_kind == jsv_pkg::KIND_OBJECT) ? jsv_pkg::ST_OBJ_FIRST
                                                     : jsv_pkg::ST_ARR_FIRST;
      end
    end

    // close a level, closing the top level ends the document
    if (do_close) begin
      pop_c = (depth_i != '0);
      if (depth_i <= DepthW'(1)) begin
        hit      = 1'b1;
        hit_code = jsv_pkg::VERDICT_OK;
      end else begin
        st_d = jsv_pkg::ST_AFTER;
      end
    end
  end

  // stack command
  always_comb begin
    stk_cmd_o.clear = step_i && is_last_i;
    stk_cmd_o.push  = step_i && !given_q && push_c;
    stk_cmd_o.pop   = step_i && !given_q && pop_c;
    stk_cmd_o.kind  = open_kind;
  end

  // result word
  always_comb begin
    res_valid_o   = !given_q && (hit || is_last_i);
    res_verdict_o = hit_code;
    if (!hit) begin
      res_verdict_o = (st_d == jsv_pkg::ST_START) ? jsv_pkg::VERDICT_BAD_START
                                                  : jsv_pkg::VERDICT_MALFORMED;
    end
  end
  assign res_pos_o = pos_q;

  // state registers, the last byte returns everything to reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= jsv_pkg::ST_START;
      lit_kind_q <= jsv_pkg::LIT_TRUE;
      lit_idx_q  <= '0;
      given_q    <= 1'b0;
      pos_q      <= '0;
    end else if (step_i) begin
      if (is_last_i) begin
        st_q       <= jsv_pkg::ST_START;
        lit_kind_q <= jsv_pkg::LIT_TRUE;
        lit_idx_q  <= '0;
        given_q    <= 1'b0;
        pos_q      <= '0;
      end else begin
        if (!given_q) begin
          if (hit) begin
            given_q <= 1'b1;
          end else begin
            st_q       <= st_d;
            lit_kind_q <= lit_kind_d;
            lit_idx_q  <= lit_idx_d;
          end
        end
        if (pos_q != '1) begin
          pos_q <= pos_q + 16'd1;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/json_syntax_validator.sv
// top level: input word register, parser, kind stack and result register
// flow: a word is taken into the input word register, parsed from there when the
//   result register can take a word, and its verdict is registered there for the output
// throughput: one byte per cycle while the result register is not held by out_ready_i
// reset: rst_ni clears parser state, nesting depth, position and both valid flags;
//   the kind stack memory is not cleared, entries are written before they are read
`default_nettype none

module json_syntax_validator #(
  parameter int unsigned MaxDepth = jsv_pkg::MAX_NEST_DEPTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  text_byte_i,
  input  wire logic        is_last_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       verdict_o,
  output logic [15:0]      byte_position_o
);

  localparam int unsigned DepthW = $clog2(MaxDepth + 1);

  logic              in_vq;
  logic [7:0]        byte_q;
  logic              last_q;
  logic              out_vq;
  logic [1:0]        verdict_q;
  logic [15:0]       pos_q;
  logic              advance;
  logic              step;
  logic              res_valid;
  logic [1:0]        res_verdict;
  logic [15:0]       res_pos;
  logic [DepthW-1:0] depth;
  logic              top_kind;
  jsv_pkg::stk_cmd_t stk_cmd;

  // the input register moves on whenever the result register can take a word
  assign advance    = !out_vq || out_ready_i;
  assign step       = in_vq && advance;
  assign in_ready_o = !in_vq || advance;

  // input word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vq <= 1'b0;
    end else if (in_ready_o) begin
      in_vq <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= text_byte_i;
      last_q <= is_last_i;
    end
  end

  jsv_parser #(
    .MaxDepth (MaxDepth)
  ) u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .text_byte_i   (byte_q),
    .is_last_i     (last_q),
    .depth_i       (depth),
    .top_kind_i    (top_kind),
    .stk_cmd_o     (stk_cmd),
    .res_valid_o   (res_valid),
    .res_verdict_o (res_verdict),
    .res_pos_o     (res_pos)
  );

  jsv_kind_stack #(
    .MaxDepth (MaxDepth)
  ) u_stack (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (stk_cmd),
    .depth_o    (depth),
    .top_kind_o (top_kind)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vq <= 1'b0;
    end else if (advance) begin
      out_vq <= step && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      verdict_q <= res_verdict;
      pos_q     <= res_pos;
    end
  end

  assign out_valid_o     = out_vq;
  assign verdict_o       = verdict_q;
  assign byte_position_o = pos_q;

endmodule

`default_nettype wire

>>> rtl/jsv_checker.sv
// port-level checks for the json syntax validator and their bind
`default_nettype none

module jsv_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [1:0]  verdict_o,
  input wire logic [15:0] byte_position_o
);

  // a stalled result word holds
  property p_out_hold;
    @(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && !out_ready_i) |=>
        (out_valid_o && $stable(verdict_o) && $stable(byte_position_o));
  endproperty
  a_out_hold: assert property (p_out_hold)
    else $error("result word changed while stalled");

  // input is only held off by a waiting result
  property p_ready_when_empty;
    @(posedge clk_i) disable iff (!rst_ni)
      !out_valid_o |-> in_ready_o;
  endproperty
  a_ready_when_empty: assert property (p_ready_when_empty)
    else $error("input stalled with no result waiting");

  // ok needs an opening and a closing bracket, so never at the first byte
  property p_ok_not_first;
    @(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && (verdict_o == jsv_pkg::VERDICT_OK)) |-> (byte_position_o != 16'd0);
  endproperty
  a_ok_not_first: assert property (p_ok_not_first)
    else $error("ok verdict at first byte");

  // too deep needs at least one open level before it
  property p_deep_not_first;
    @(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && (verdict_o == jsv_pkg::VERDICT_TOO_DEEP)) |->
        (byte_position_o != 16'd0);
  endproperty
  a_deep_not_first: assert property (p_deep_not_first)
    else $error("too deep verdict at first byte");

  // a result appears only after a word has been taken in
  property p_result_after_input;
    @(posedge clk_i) disable iff (!rst_ni)
      $rose(out_valid_o) |-> $past(in_ready_o) || $past(in_valid_i, 2) || $past(in_valid_i);
  endproperty
  a_result_after_input: assert property (p_result_after_input)
    else $error("result with no input word");

endmodule

bind json_syntax_validator jsv_checker u_jsv_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .verdict_o       (verdict_o),
  .byte_position_o (byte_position_o)
);

`default_nettype wire

>>> verif/tb_json_syntax_validator.sv
`timescale 1ns / 1ps
// testbench for the json syntax validator: directed table and random documents

module tb_json_syntax_validator;

  localparam int unsigned IDLE_PCT     = 24;
  localparam int unsigned RANDOM_WORDS = 1400;
  localparam int unsigned HOLD_AFTER   = 25;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned STALL_LIMIT  = 5000;
  localparam int unsigned DRAIN_CYCLES = 16;

  // how a stimulus word gets its expectation
  typedef enum logic [1:0] {
    BY_PREDICTOR,
    NO_VERDICT,
    GIVES_VERDICT
  } row_check_e;

  typedef struct {
    logic [7:0]  ch;
    logic        last;
    row_check_e  check;
    logic [1:0]  verdict;
    logic [15:0] pos;
  } text_word_t;

  typedef struct packed {
    logic [1:0]  verdict;
    logic [15:0] pos;
  } verdict_rec_t;

  typedef struct packed {
    logic       given;
    logic [1:0] verdict;
  } ruling_t;

  localparam ruling_t NO_RULING = '{1'b0, jsv_pkg::VERDICT_OK};

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [7:0]  text_byte_i = jsv_pkg::CH_SPACE;
  logic        is_last_i   = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  verdict_o;
  logic [15:0] byte_position_o;

  json_syntax_validator uut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .text_byte_i,
    .is_last_i,
    .out_valid_o,
    .out_ready_i,
    .verdict_o,
    .byte_position_o
  );

  // directed words: bad start, early end, zero bytes, trailing comma, mismatched close, ok with a byte after it
  text_word_t directed [24] = '{
    '{jsv_pkg::CH_NUL,    1'b1, GIVES_VERDICT, jsv_pkg::VERDICT_BAD_START, 16'd0},
    '{8'hFF,              1'b1, GIVES_VERDICT, jsv_pkg::VERDICT_BAD_START, 16'd0},
    '{jsv_pkg::CH_SPACE,  1'b0, NO_VERDICT,    jsv_pkg::VERDICT_OK,        16'd0},
    '{jsv_pkg::CH_TAB,    1'b1, GIVES_VERDICT, jsv_pkg::VERDICT_BAD_START, 16'd1},
    '{jsv_pkg::CH_LBRACK, 1'b0, NO_VERDICT,    jsv_pkg::VERDICT_OK,        16'd0},
    '{jsv_pkg::CH_NUL,    1'b1, GIVES_VERDICT, jsv_pkg::VERDICT_MALFORMED, 16'd1},
    '{jsv_pkg::CH_LBRACE, 1'b0, NO_VERDICT,    jsv_pkg::VERDICT_OK,        16'd0},
    '{jsv_pkg::CH_QUOTE,  1'b0, NO_VERDICT,    jsv_pkg::VERDICT_OK,        16'd0},
    '{jsv_pkg::CH_BSLASH, 1'b0, NO_VERDICT,    jsv_pkg::VERDICT_OK,        16'd0},
    '{jsv_pkg::CH_NUL,    1'b1, GIVES_VERDICT, jsv_pkg::VERDICT_MALFORMED, 16'd3},
    '{jsv_pkg::CH_LBRACK, 1'b0, BY_PREDICTOR,  jsv_pkg::VERDICT_OK,        16'd0},
    '{jsv_pkg::CH_NINE,   1'b0, BY_PREDICTOR,  jsv_pkg::VERDICT_OK,        16'd0},
    '{jsv_pkg::CH_COMMA,  1'b0, BY_PREDICTOR,  jsv_pkg::VERDICT_OK,        16'd0},
    '{jsv_pkg::CH_RBRACK, 1'b1, GIVES_VERDICT, jsv_pkg::VERDICT_MALFORMED, 16'd3},
    '{jsv_pkg::CH_LBRACE, 1'b0, NO_VERDICT,    jsv_pkg::VERDICT_OK,        16'd0},
    '{jsv_pkg::CH_RBRACK, 1'b1, GIVES_VERDICT, jsv_pkg::VERDICT_MALFORMED, 16'd1},
    '{jsv_pkg::CH_LBRACK, 1'b0, BY_PREDICTOR,  jsv_pkg::VERDICT_OK,        16'd0},
    '{"t",                1'b0, BY_PREDICTOR,  jsv_pkg::VERDICT_OK,        16'd0},
    '{"r",                1'b0, BY_PREDICTOR,  jsv_pkg::VERDICT_OK,        16'd0},
    '{"u",                1'b0, BY_PREDICTOR,  jsv_pkg::VERDICT_OK,        16'd0},
    '{"e",                1'b0, BY_PREDICTOR,  jsv_pkg::VERDICT_OK,        16'd0},
    '{jsv_pkg::CH_RBRACK, 1'b0, GIVES_VERDICT, jsv_pkg::VERDICT_OK,        16'd5},
    '{"x",                1'b1, NO_VERDICT,    jsv_pkg::VERDICT_OK,        16'd0},
    '{jsv_pkg::CH_LBRACE, 1'b1, GIVES_VERDICT, jsv_pkg::VERDICT_MALFORMED, 16'd0}
  };

  text_word_t   word_q [$];
  verdict_rec_t verdict_q [$];
  logic [7:0]   doc_bytes [$];

  int unsigned words_sent;
  int unsigned docs_sent;
  int unsigned verdicts_seen;
  int unsigned fail_count;
  int unsigned tally [4];

  // parser model state
  logic [3:0]  pstate;
  logic        kind_stk [jsv_pkg::MAX_NEST_DEPTH];
  int unsigned open_levels;
  logic [1:0]  lit_kind;
  logic [2:0]  lit_idx;
  logic [15:0] byte_count;
  bit          decided;

  string lit_word [3] = '{"true", "false", "null"};

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic bit quiet();
    return words_sent >= 500 && words_sent < 900;
  endfunction

  function automatic bit blank(logic [7:0] ch);
    return ch == jsv_pkg::CH_SPACE || ch == jsv_pkg::CH_TAB ||
           ch == jsv_pkg::CH_LF || ch == jsv_pkg::CH_CR;
  endfunction

  function automatic bit numeral(logic [7:0] ch);
    return ch >= jsv_pkg::CH_ZERO && ch <= jsv_pkg::CH_NINE;
  endfunction

  function automatic ruling_t rule(logic [1:0] v);
    return '{1'b1, v};
  endfunction

  function automatic void clear_parser();
    pstate      = jsv_pkg::ST_START;
    open_levels = 0;
    lit_kind    = jsv_pkg::LIT_TRUE;
    lit_idx     = '0;
    byte_count  = '0;
    decided     = 1'b0;
    foreach (kind_stk[i]) kind_stk[i] = jsv_pkg::KIND_ARRAY;
  endfunction

  function automatic logic top_kind();
    if (open_levels == 0) return jsv_pkg::KIND_ARRAY;
    return kind_stk[open_levels - 1];
  endfunction

  function automatic ruling_t open_level(logic kind);
    if (open_levels >= jsv_pkg::MAX_NEST_DEPTH) return rule(jsv_pkg::VERDICT_TOO_DEEP);
    kind_stk[open_levels] = kind;
    open_levels++;
    pstate = (kind == jsv_pkg::KIND_OBJECT) ? jsv_pkg::ST_OBJ_FIRST : jsv_pkg::ST_ARR_FIRST;
    return NO_RULING;
  endfunction

  // closing the top-level bracket finishes the document
  function automatic ruling_t close_level();
    if (open_levels > 0) open_levels--;
    if (open_levels == 0) return rule(jsv_pkg::VERDICT_OK);
    pstate = jsv_pkg::ST_AFTER;
    return NO_RULING;
  endfunction

  function automatic ruling_t start_value(logic [7:0] ch);
    if (ch == jsv_pkg::CH_QUOTE) begin
      pstate = jsv_pkg::ST_STR;
      return NO_RULING;
    end
    if (ch == jsv_pkg::CH_LBRACE) return open_level(jsv_pkg::KIND_OBJECT);
    if (ch == jsv_pkg::CH_LBRACK) return open_level(jsv_pkg::KIND_ARRAY);
    if (ch == jsv_pkg::CH_LOWER_T || ch == jsv_pkg::CH_LOWER_F ||
        ch == jsv_pkg::CH_LOWER_N) begin
      lit_kind = (ch == jsv_pkg::CH_LOWER_T) ? jsv_pkg::LIT_TRUE :
                 (ch == jsv_pkg::CH_LOWER_F) ? jsv_pkg::LIT_FALSE : jsv_pkg::LIT_NULL;
      lit_idx  = 3'd1;
      pstate   = jsv_pkg::ST_LIT;
      return NO_RULING;
    end
    if (ch == jsv_pkg::CH_MINUS || numeral(ch)) begin
      pstate = jsv_pkg::ST_NUM_INT;
      return NO_RULING;
    end
    return rule(jsv_pkg::VERDICT_MALFORMED);
  endfunction

  // advance the parser model by one text byte
  task automatic judge_byte(input logic [7:0] ch, input logic last,
                            output ruling_t r, output logic [15:0] at);
    bit redo;
    r  = NO_RULING;
    at = byte_count;
    if (!decided) begin
      redo = 1'b1;
      while (redo) begin
        redo = 1'b0;
        case (pstate)
          jsv_pkg::ST_START: begin
            if (!blank(ch)) begin
              if (ch == jsv_pkg::CH_LBRACE) r = open_level(jsv_pkg::KIND_OBJECT);
              else if (ch == jsv_pkg::CH_LBRACK) r = open_level(jsv_pkg::KIND_ARRAY);
              else r = rule(jsv_pkg::VERDICT_BAD_START);
            end
          end
          jsv_pkg::ST_ARR_FIRST: begin
            if (!blank(ch)) begin
              if (ch == jsv_pkg::CH_RBRACK) r = close_level();
              else r = start_value(ch);
            end
          end
          jsv_pkg::ST_OBJ_FIRST: begin
            if (!blank(ch)) begin
              if (ch == jsv_pkg::CH_RBRACE) r = close_level();
              else if (ch == jsv_pkg::CH_QUOTE) pstate = jsv_pkg::ST_KEY_STR;
              else r = rule(jsv_pkg::VERDICT_MALFORMED);
            end
          end
          jsv_pkg::ST_VALUE: begin
            if (!blank(ch)) r = start_value(ch);
          end
          jsv_pkg::ST_KEY: begin
            if (!blank(ch)) begin
              if (ch == jsv_pkg::CH_QUOTE) pstate = jsv_pkg::ST_KEY_STR;
              else r = rule(jsv_pkg::VERDICT_MALFORMED);
            end
          end
          jsv_pkg::ST_KEY_STR, jsv_pkg::ST_STR: begin
            if (ch == jsv_pkg::CH_NUL) begin
              r = rule(jsv_pkg::VERDICT_MALFORMED);
            end else if (ch == jsv_pkg::CH_BSLASH) begin
              pstate = (pstate == jsv_pkg::ST_KEY_STR) ? jsv_pkg::ST_KEY_ESC
                                                       : jsv_pkg::ST_STR_ESC;
            end else if (ch == jsv_pkg::CH_QUOTE) begin
              pstate = (pstate == jsv_pkg::ST_KEY_STR) ? jsv_pkg::ST_COLON
                                                       : jsv_pkg::ST_AFTER;
            end
          end
          jsv_pkg::ST_KEY_ESC: begin
            if (ch == jsv_pkg::CH_NUL) r = rule(jsv_pkg::VERDICT_MALFORMED);
            else pstate = jsv_pkg::ST_KEY_STR;
          end
          jsv_pkg::ST_STR_ESC: begin
            if (ch == jsv_pkg::CH_NUL) r = rule(jsv_pkg::VERDICT_MALFORMED);
            else pstate = jsv_pkg::ST_STR;
          end
          jsv_pkg::ST_COLON: begin
            if (!blank(ch)) begin
              if (ch == jsv_pkg::CH_COLON) pstate = jsv_pkg::ST_VALUE;
              else r = rule(jsv_pkg::VERDICT_MALFORMED);
            end
          end
          jsv_pkg::ST_LIT: begin
            if (lit_idx >= lit_word[lit_kind].len() || ch != lit_word[lit_kind][lit_idx]) begin
              r = rule(jsv_pkg::VERDICT_MALFORMED);
            end else begin
              lit_idx++;
              if (lit_idx >= lit_word[lit_kind].len()) pstate = jsv_pkg::ST_AFTER;
            end
          end
          // numbers end on the first byte that does not fit, which is then reparsed
          jsv_pkg::ST_NUM_INT: begin
            if (ch == jsv_pkg::CH_DOT) pstate = jsv_pkg::ST_NUM_FRAC;
            else if (ch == jsv_pkg::CH_LOWER_E || ch == jsv_pkg::CH_UPPER_E) begin
              pstate = jsv_pkg::ST_NUM_ESIGN;
            end else if (!numeral(ch)) begin
              pstate = jsv_pkg::ST_AFTER;
              redo   = 1'b1;
            end
          end
          jsv_pkg::ST_NUM_FRAC: begin
            if (ch == jsv_pkg::CH_LOWER_E || ch == jsv_pkg::CH_UPPER_E) begin
              pstate = jsv_pkg::ST_NUM_ESIGN;
            end else if (!numeral(ch)) begin
              pstate = jsv_pkg::ST_AFTER;
              redo   = 1'b1;
            end
          end
          jsv_pkg::ST_NUM_ESIGN: begin
            if (ch == jsv_pkg::CH_PLUS || ch == jsv_pkg::CH_MINUS || numeral(ch)) begin
              pstate = jsv_pkg::ST_NUM_EDIG;
            end else begin
              pstate = jsv_pkg::ST_AFTER;
              redo   = 1'b1;
            end
          end
          jsv_pkg::ST_NUM_EDIG: begin
            if (!numeral(ch)) begin
              pstate = jsv_pkg::ST_AFTER;
              redo   = 1'b1;
            end
          end
          default: begin
            if (!blank(ch)) begin
              if (ch == jsv_pkg::CH_COMMA) begin
                pstate = (top_kind() == jsv_pkg::KIND_OBJECT) ? jsv_pkg::ST_KEY
                                                              : jsv_pkg::ST_VALUE;
              end else if (ch == jsv_pkg::CH_RBRACK && top_kind() == jsv_pkg::KIND_ARRAY) begin
                r = close_level();
              end else if (ch == jsv_pkg::CH_RBRACE && top_kind() == jsv_pkg::KIND_OBJECT) begin
                r = close_level();
              end else begin
                r = rule(jsv_pkg::VERDICT_MALFORMED);
              end
            end
          end
        endcase
      end
      // document cut short
      if (!r.given && last) begin
        r = rule((pstate == jsv_pkg::ST_START) ? jsv_pkg::VERDICT_BAD_START
                                               : jsv_pkg::VERDICT_MALFORMED);
      end
      if (r.given) decided = 1'b1;
    end
    if (byte_count != 16'hFFFF) byte_count++;
    if (last) clear_parser();
  endtask

  // document generation
  function automatic void push_word(logic [7:0] ch, logic last);
    word_q.push_back('{ch, last, BY_PREDICTOR, jsv_pkg::VERDICT_OK, 16'd0});
  endfunction

  task automatic put_blank(int unsigned most);
    repeat ($urandom_range(most)) begin
      case ($urandom_range(3))
        0:       doc_bytes.push_back(jsv_pkg::CH_SPACE);
        1:       doc_bytes.push_back(jsv_pkg::CH_TAB);
        2:       doc_bytes.push_back(jsv_pkg::CH_LF);
        default: doc_bytes.push_back(jsv_pkg::CH_CR);
      endcase
    end
  endtask

  // string body with random bytes and escapes of any nonzero byte
  task automatic put_string();
    logic [7:0] c;
    doc_bytes.push_back(jsv_pkg::CH_QUOTE);
    repeat ($urandom_range(5)) begin
      if ($urandom_range(4) == 0) begin
        doc_bytes.push_back(jsv_pkg::CH_BSLASH);
        doc_bytes.push_back(8'($urandom_range(255, 1)));
      end else begin
        c = 8'($urandom_range(255, 1));
        if (c == jsv_pkg::CH_QUOTE || c == jsv_pkg::CH_BSLASH) c = "a";
        doc_bytes.push_back(c);
      end
    end
    doc_bytes.push_back(jsv_pkg::CH_QUOTE);
  endtask

  task automatic put_digits(int unsigned count);
    repeat (count) doc_bytes.push_back(8'(jsv_pkg::CH_ZERO + $urandom_range(9)));
  endtask

  // lax numbers: lone minus, empty fraction and empty exponent included
  task automatic put_number();
    bit          neg;
    int unsigned count;
    neg   = ($urandom_range(2) == 0);
    count = $urandom_range(3);
    if (neg) doc_bytes.push_back(jsv_pkg::CH_MINUS);
    if (!neg && count == 0) count = 1;
    put_digits(count);
    if ($urandom_range(2) == 0) begin
      doc_bytes.push_back(jsv_pkg::CH_DOT);
      put_digits($urandom_range(2));
    end
    if ($urandom_range(3) == 0) begin
      doc_bytes.push_back($urandom_range(1) ? jsv_pkg::CH_LOWER_E : jsv_pkg::CH_UPPER_E);
      if ($urandom_range(1)) begin
        doc_bytes.push_back($urandom_range(1) ? jsv_pkg::CH_PLUS : jsv_pkg::CH_MINUS);
      end
      put_digits($urandom_range(2));
    end
  endtask

  task automatic put_literal();
    string w;
    w = lit_word[$urandom_range(2)];
    for (int i = 0; i < w.len(); i++) doc_bytes.push_back(w[i]);
  endtask

  task automatic put_container(bit obj, int unsigned room);
    int unsigned members;
    members = $urandom_range(3);
    doc_bytes.push_back(obj ? jsv_pkg::CH_LBRACE : jsv_pkg::CH_LBRACK);
    put_blank(1);
    for (int unsigned m = 0; m < members; m++) begin
      if (m != 0) begin
        doc_bytes.push_back(jsv_pkg::CH_COMMA);
        put_blank(1);
      end
      if (obj) begin
        put_string();
        put_blank(1);
        doc_bytes.push_back(jsv_pkg::CH_COLON);
        put_blank(1);
      end
      put_value(room);
      put_blank(1);
    end
    doc_bytes.push_back(obj ? jsv_pkg::CH_RBRACE : jsv_pkg::CH_RBRACK);
  endtask

  task automatic put_value(int unsigned room);
    int unsigned pick;
    pick = (room == 0) ? $urandom_range(4, 2) : $urandom_range(4);
    case (pick)
      0:       put_container(1'b1, room - 1);
      1:       put_container(1'b0, room - 1);
      2:       put_string();
      3:       put_literal();
      default: put_number();
    endcase
  endtask

  // nesting around the depth limit
  task automatic put_deep_nest();
    logic        kinds [$];
    int unsigned levels;
    levels = $urandom_range(36, 28);
    repeat (levels) begin
      if ($urandom_range(1)) begin
        kinds.push_back(jsv_pkg::KIND_OBJECT);
        doc_bytes.push_back(jsv_pkg::CH_LBRACE);
        put_string();
        doc_bytes.push_back(jsv_pkg::CH_COLON);
      end else begin
        kinds.push_back(jsv_pkg::KIND_ARRAY);
        doc_bytes.push_back(jsv_pkg::CH_LBRACK);
      end
    end
    put_value(0);
    while (kinds.size() != 0) begin
      doc_bytes.push_back((kinds.pop_back() == jsv_pkg::KIND_OBJECT) ? jsv_pkg::CH_RBRACE
                                                                     : jsv_pkg::CH_RBRACK);
    end
  endtask

  task automatic queue_document();
    int unsigned style;
    int unsigned idx;
    doc_bytes.delete();
    style = $urandom_range(99);
    if (style < 8) begin
      repeat ($urandom_range(4, 1)) doc_bytes.push_back(8'($urandom_range(255)));
    end else if (style < 16) begin
      put_blank(2);
      put_deep_nest();
    end else begin
      put_blank(3);
      put_container(1'($urandom_range(1)), $urandom_range(2));
    end
    // damage about a quarter of the documents
    if (style >= 16 && style < 40) begin
      idx = $urandom_range(doc_bytes.size() - 1);
      case ($urandom_range(2))
        0:       doc_bytes[idx] = 8'($urandom_range(255));
        1:       doc_bytes = doc_bytes[0:idx];
        default: doc_bytes.insert(idx, jsv_pkg::CH_NUL);
      endcase
    end
    // trailing bytes, ignored once a verdict is out
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(3, 1)) doc_bytes.push_back(8'($urandom_range(255)));
    end
    foreach (doc_bytes[i]) push_word(doc_bytes[i], i == doc_bytes.size() - 1);
  endtask

  // sender: offers words, predicts on each accepted one
  initial begin : sender
    text_word_t  cur;
    ruling_t     got;
    logic [15:0] at;
    clear_parser();
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (in_valid_i && in_ready_o) begin
        judge_byte(cur.ch, cur.last, got, at);
        words_sent++;
        if (cur.last) docs_sent++;
        case (cur.check)
          GIVES_VERDICT: verdict_q.push_back('{cur.verdict, cur.pos});
          BY_PREDICTOR:  if (got.given) verdict_q.push_back('{got.verdict, at});
          default: ;
        endcase
      end
      if (!in_valid_i || in_ready_o) begin
        if (word_q.size() == 0 || (!quiet() && $urandom_range(99) < IDLE_PCT)) begin
          in_valid_i <= 1'b0;
        end else begin
          cur = word_q.pop_front();
          in_valid_i  <= 1'b1;
          text_byte_i <= cur.ch;
          is_last_i   <= cur.last;
        end
      end
    end
  end

  // receiver: checks each verdict word against the oldest expectation
  initial begin : receiver
    verdict_rec_t want;
    int unsigned  hold_left;
    bit           held;
    hold_left = 0;
    held      = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        verdicts_seen++;
        if (verdict_q.size() == 0) begin
          $error("verdict %0d at byte_position %0d with none expected",
                 verdict_o, byte_position_o);
          fail_count++;
        end else begin
          want = verdict_q.pop_front();
          tally[want.verdict]++;
          if (verdict_o !== want.verdict) begin
            $error("verdict: expected %0d, got %0d", want.verdict, verdict_o);
            fail_count++;
          end
          if (byte_position_o !== want.pos) begin
            $error("byte_position: expected %0d, got %0d", want.pos, byte_position_o);
            fail_count++;
          end
        end
      end
      // one long hold-off so the block backs up into its input
      if (!held && verdicts_seen == HOLD_AFTER) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= quiet() || $urandom_range(99) >= IDLE_PCT;
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  initial begin : watchdog
    int unsigned stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stalled = 0;
      else stalled++;
    end
    $display("tb_json_syntax_validator: errors");
    $finish;
  end

  initial begin : main
    int unsigned start;
    foreach (directed[i]) word_q.push_back(directed[i]);
    start = word_q.size();
    while (word_q.size() - start < RANDOM_WORDS) queue_document();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (word_q.size() != 0 || in_valid_i || verdict_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run: %0d bytes in %0d documents, %0d verdicts, with one long output hold-off",
             words_sent, docs_sent, verdicts_seen);
    $display("verdict mix: ok %0d, bad start %0d, malformed %0d, too deep %0d",
             tally[jsv_pkg::VERDICT_OK], tally[jsv_pkg::VERDICT_BAD_START],
             tally[jsv_pkg::VERDICT_MALFORMED], tally[jsv_pkg::VERDICT_TOO_DEEP]);
    if (fail_count == 0) begin
      $display("tb_json_syntax_validator: clean");
    end else begin
      $display("tb_json_syntax_validator: errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/jsv_pkg.sv
rtl/jsv_kind_stack.sv
rtl/jsv_parser.sv
rtl/json_syntax_validator.sv
rtl/jsv_checker.sv
verif/tb_json_syntax_validator.sv
